FILE: hdl/esd_pkg.sv
// Shared types and constants for the escape sequence decoder.
// No dependencies; every other file of the block uses this package.
package esd_pkg;

	// Depth of the output queue, in result beats.
	localparam int OUT_DEPTH = 8;

	// Character codes that the decoder looks for.
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_X         = 8'h78;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_SEVEN     = 8'h37;
	localparam logic [7:0] CH_NINE      = 8'h39;
	localparam logic [7:0] CH_LC_A      = 8'h61;
	localparam logic [7:0] CH_LC_F      = 8'h66;
	localparam logic [7:0] CH_UC_A      = 8'h41;
	localparam logic [7:0] CH_UC_F      = 8'h46;

	// Input beat: one text byte or an end mark.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} in_beat_t;

	// Output beat: one decoded byte.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_beat_t;

	// Results of one decoded item, handed from the decoder to the output queue.
	typedef struct packed {
		logic [1:0]      count;
		logic [2:0][7:0] bytes;
	} result_t;

	// Decoder state, one-hot.
	typedef enum logic [4:0] {
		MODE_IDLE = 5'b00001,
		MODE_ESC  = 5'b00010,
		MODE_OCT  = 5'b00100,
		MODE_HEX0 = 5'b01000,
		MODE_HEX1 = 5'b10000
	} mode_t;

endpackage

FILE: hdl/esd_decode.sv
// Escape decoder core: state registers and the single-pass decode logic.
// Depends on esd_pkg for beat types, character codes and the state encoding.
module esd_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  esd_pkg::in_beat_t item,
	output esd_pkg::result_t  result
);

	esd_pkg::mode_t mode_q, mode_d;
	logic [7:0]     octal_q, octal_d;
	logic [7:0]     held_q, held_d;

	// Hex digit character to its value; valid only for hex digits.
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] t;
		begin
			if (c > esd_pkg::CH_NINE) begin
				t = c - 8'h37;
			end else begin
				t = c - esd_pkg::CH_ZERO;
			end
			return t[3:0];
		end
	endfunction

	// Character classes of the current byte.
	logic [7:0] c;
	logic       c_oct, c_hex, c_letter;
	logic [7:0] c_code;
	logic [10:0] oct_next;

	assign c = item.in_byte;
	assign c_oct = (c >= esd_pkg::CH_ZERO) && (c <= esd_pkg::CH_SEVEN);
	assign c_hex = ((c >= esd_pkg::CH_ZERO) && (c <= esd_pkg::CH_NINE)) ||
		((c >= esd_pkg::CH_LC_A) && (c <= esd_pkg::CH_LC_F)) ||
		((c >= esd_pkg::CH_UC_A) && (c <= esd_pkg::CH_UC_F));
	assign oct_next = {octal_q, c[2:0]};

	// Named control letters and their codes.
	always_comb begin
		c_letter = 1'b1;
		unique case (c)
			8'h6E:   c_code = 8'h0A;
			8'h72:   c_code = 8'h0D;
			8'h74:   c_code = 8'h09;
			8'h76:   c_code = 8'h0B;
			8'h61:   c_code = 8'h01;
			8'h66:   c_code = 8'h0C;
			8'h65:   c_code = 8'h1B;
			default: begin
				c_code   = 8'h00;
				c_letter = 1'b0;
			end
		endcase
	end

	// Decode one item: results and next state.
	always_comb begin
		logic [1:0] n;
		n              = 2'd0;
		result.bytes   = '0;
		mode_d         = mode_q;
		octal_d        = octal_q;
		held_d         = held_q;
		if (item.end_of_string) begin
			// End mark flushes pending bytes; a lone backslash is dropped.
			unique case (mode_q)
				esd_pkg::MODE_OCT: begin
					result.bytes[0] = octal_q;
					n = 2'd1;
				end
				esd_pkg::MODE_HEX0: begin
					result.bytes[0] = esd_pkg::CH_X;
					n = 2'd1;
				end
				esd_pkg::MODE_HEX1: begin
					result.bytes[0] = esd_pkg::CH_X;
					result.bytes[1] = held_q;
					n = 2'd2;
				end
				default: n = 2'd0;
			endcase
			mode_d  = esd_pkg::MODE_IDLE;
			octal_d = 8'h00;
			held_d  = 8'h00;
		end else begin
			unique case (mode_q)
				esd_pkg::MODE_ESC: begin
					mode_d = esd_pkg::MODE_IDLE;
					if (c_letter) begin
						result.bytes[0] = c_code;
						n = 2'd1;
					end else if (c_oct) begin
						octal_d = {5'd0, c[2:0]};
						mode_d  = esd_pkg::MODE_OCT;
					end else if (c == esd_pkg::CH_X) begin
						mode_d = esd_pkg::MODE_HEX0;
					end else begin
						result.bytes[0] = c;
						n = 2'd1;
					end
				end
				esd_pkg::MODE_OCT: begin
					if (c_oct) begin
						if (oct_next[10:8] != 3'd0) begin
							// Value reached 256: emit the low byte and stop.
							result.bytes[0] = oct_next[7:0];
							n       = 2'd1;
							octal_d = 8'h00;
							mode_d  = esd_pkg::MODE_IDLE;
						end else begin
							octal_d = oct_next[7:0];
						end
					end else begin
						// Run ended: emit the value, then treat the byte as idle.
						result.bytes[0] = octal_q;
						n       = 2'd1;
						octal_d = 8'h00;
						mode_d  = esd_pkg::MODE_IDLE;
						if (c == esd_pkg::CH_BACKSLASH) begin
							mode_d = esd_pkg::MODE_ESC;
						end else begin
							result.bytes[1] = c;
							n = 2'd2;
						end
					end
				end
				esd_pkg::MODE_HEX0: begin
					if (c_hex) begin
						held_d = c;
						mode_d = esd_pkg::MODE_HEX1;
					end else begin
						result.bytes[0] = esd_pkg::CH_X;
						n      = 2'd1;
						mode_d = esd_pkg::MODE_IDLE;
						if (c == esd_pkg::CH_BACKSLASH) begin
							mode_d = esd_pkg::MODE_ESC;
						end else begin
							result.bytes[1] = c;
							n = 2'd2;
						end
					end
				end
				esd_pkg::MODE_HEX1: begin
					mode_d = esd_pkg::MODE_IDLE;
					held_d = 8'h00;
					if (c_hex) begin
						result.bytes[0] = {hex_val(held_q), hex_val(c)};
						n = 2'd1;
					end else begin
						// Failed hex escape: emit it literally, then the byte as idle.
						result.bytes[0] = esd_pkg::CH_X;
						result.bytes[1] = held_q;
						n = 2'd2;
						if (c == esd_pkg::CH_BACKSLASH) begin
							mode_d = esd_pkg::MODE_ESC;
						end else begin
							result.bytes[2] = c;
							n = 2'd3;
						end
					end
				end
				default: begin
					mode_d = esd_pkg::MODE_IDLE;
					if (c == esd_pkg::CH_BACKSLASH) begin
						mode_d = esd_pkg::MODE_ESC;
					end else begin
						result.bytes[0] = c;
						n = 2'd1;
					end
				end
			endcase
		end
		result.count = n;
	end

	// State advances only when an item is decoded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= esd_pkg::MODE_IDLE;
			octal_q <= 8'h00;
			held_q  <= 8'h00;
		end else if (fire) begin
			mode_q  <= mode_d;
			octal_q <= octal_d;
			held_q  <= held_d;
		end
	end

endmodule

FILE: hdl/esd_out_fifo.sv
// Output queue: takes up to three result beats per cycle, gives one per cycle while out_ready is high.
// Depends on esd_pkg for the result and output beat types.
module esd_out_fifo #(
	parameter int DEPTH = esd_pkg::OUT_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  esd_pkg::result_t   result,
	output logic               room,
	output logic               out_valid,
	input  logic               out_ready,
	output esd_pkg::out_beat_t out_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] LIMIT = CW'(DEPTH - 3);
	localparam logic [PW:0]   DEPTH_W = (PW + 1)'(DEPTH);

	esd_pkg::out_beat_t mem_q [DEPTH];
	logic [PW-1:0] rd_ptr_q, wr_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;
	logic [1:0]    n_push;

	// Pointer plus a small offset, wrapped at the depth.
	function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [1:0] k);
		logic [PW:0] s;
		begin
			s = {1'b0, p} + {{(PW - 1){1'b0}}, k};
			if (s >= DEPTH_W) begin
				s = s - DEPTH_W;
			end
			return s[PW-1:0];
		end
	endfunction

	assign room      = count_q <= LIMIT;
	assign out_valid = count_q != '0;
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign n_push    = push ? result.count : 2'd0;

	// Write the beats of one item, marking the last one.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (2'(k) < n_push) begin
				mem_q[ptr_add(wr_ptr_q, 2'(k))] <= '{
					out_byte: result.bytes[k],
					out_last: (2'(k + 1) == n_push)
				};
			end
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= ptr_add(wr_ptr_q, n_push);
			if (pop) begin
				rd_ptr_q <= ptr_add(rd_ptr_q, 2'd1);
			end
			count_q <= count_q + CW'(n_push) - CW'(pop);
		end
	end

endmodule

FILE: hdl/escape_sequence_decoder_unit.sv
// Backslash escape decoder: one input byte per cycle while the output queue has room, zero to three output bytes.
// Latency: a beat's first result passes through the input register and then the
// output queue before it can be taken.
// Throughput: one item per cycle; the output port drains one beat per cycle when out_ready
// is high, so items with several results hold input off when the queue has under three free slots.
// Reset: arst_n clears the decode state, the input stage and the output queue.
// Depends on esd_pkg, esd_decode and esd_out_fifo.
module escape_sequence_decoder_unit #(
	parameter int OUT_DEPTH = esd_pkg::OUT_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  esd_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output esd_pkg::out_beat_t out_data
);

	esd_pkg::in_beat_t in_s1;
	logic              valid_s1;
	logic              room;
	logic              go_s1;
	esd_pkg::result_t  result;

	// The input stage drains into the decoder whenever the queue has room for three.
	assign go_s1    = valid_s1 && room;
	assign in_ready = !valid_s1 || go_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
	end

	// Decoder with its escape state.
	esd_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (go_s1),
		.item   (in_s1),
		.result (result)
	);

	// Result queue toward the output port.
	esd_out_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (go_s1),
		.result    (result),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: verif/escape_sequence_decoder_unit_test.sv
// Self-checking testbench for escape_sequence_decoder_unit: directed rows, then random escape text.
// Every output beat is checked against the directed table's expectations or an in-bench decoder model.
// Depends on esd_pkg and the escape_sequence_decoder_unit RTL.
`timescale 1ns / 1ps

module escape_sequence_decoder_unit_test;

	// Escape letters and the control codes they stand for, lined up by index.
	localparam logic [6:0][7:0] ESC_LETTERS = {"e", "f", "a", "v", "t", "r", "n"};
	localparam logic [6:0][7:0] ESC_CODES   = {8'h1B, 8'h0C, 8'h01, 8'h0B, 8'h09, 8'h0D, 8'h0A};

	// Up to three decoded characters caused by one input beat.
	typedef struct packed {
		logic [1:0]      count;
		logic [2:0][7:0] chars;
	} decoded_t;

	// One row of the directed table; typed rows carry their expected characters.
	typedef struct packed {
		logic [7:0] chr;
		logic       eos;
		logic       typed;
		logic [1:0] count;
		logic [7:0] r0;
		logic [7:0] r1;
		logic [7:0] r2;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	esd_pkg::in_beat_t  in_data;
	logic               out_valid;
	logic               out_ready;
	esd_pkg::out_beat_t out_data;

	// Model state of the decoder.
	esd_pkg::mode_t esc_mode   = esd_pkg::MODE_IDLE;
	logic [8:0]     octal_acc  = '0;
	logic [7:0]     first_hex  = '0;

	esd_pkg::out_beat_t pending_chars[$];
	int        mismatch_count = 0;
	bit        tx_steady = 1'b0;
	bit        rx_steady = 1'b0;
	int        rx_hold   = 0;

	dir_row_t directed_rows [25] = '{
		'{"A",                   0, 1, 1, "A",   0,   0},
		'{8'h00,                 0, 1, 1, 8'h00, 0,   0},
		'{8'hFF,                 0, 1, 1, 8'hFF, 0,   0},
		'{8'hFF,                 1, 1, 0, 0,     0,   0},
		'{esd_pkg::CH_BACKSLASH, 0, 1, 0, 0,     0,   0},
		'{"n",                   0, 1, 1, 8'h0A, 0,   0},
		'{esd_pkg::CH_BACKSLASH, 0, 0, 0, 0,     0,   0},
		'{"4",                   0, 0, 0, 0,     0,   0},
		'{"0",                   0, 0, 0, 0,     0,   0},
		'{"0",                   0, 1, 1, 8'h00, 0,   0},
		'{esd_pkg::CH_BACKSLASH, 0, 0, 0, 0,     0,   0},
		'{"x",                   0, 0, 0, 0,     0,   0},
		'{"F",                   0, 0, 0, 0,     0,   0},
		'{"f",                   0, 1, 1, 8'hFF, 0,   0},
		'{esd_pkg::CH_BACKSLASH, 0, 0, 0, 0,     0,   0},
		'{"x",                   0, 0, 0, 0,     0,   0},
		'{"g",                   0, 1, 2, "x",   "g", 0},
		'{esd_pkg::CH_BACKSLASH, 0, 0, 0, 0,     0,   0},
		'{"x",                   0, 0, 0, 0,     0,   0},
		'{"a",                   0, 0, 0, 0,     0,   0},
		'{esd_pkg::CH_BACKSLASH, 0, 1, 2, "x",   "a", 0},
		'{"7",                   0, 0, 0, 0,     0,   0},
		'{8'h00,                 1, 1, 1, 8'h07, 0,   0},
		'{esd_pkg::CH_BACKSLASH, 0, 0, 0, 0,     0,   0},
		'{8'hFF,                 1, 1, 0, 0,     0,   0}
	};

	escape_sequence_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit is_hex(logic [7:0] c);
		return (c >= esd_pkg::CH_ZERO && c <= esd_pkg::CH_NINE) ||
			(c >= esd_pkg::CH_LC_A && c <= esd_pkg::CH_LC_F) ||
			(c >= esd_pkg::CH_UC_A && c <= esd_pkg::CH_UC_F);
	endfunction

	function automatic bit is_octal(logic [7:0] c);
		return c >= esd_pkg::CH_ZERO && c <= esd_pkg::CH_SEVEN;
	endfunction

	// Letters map through 'A' minus ten; the low nibble also works for lowercase.
	function automatic logic [3:0] hex_val(logic [7:0] c);
		logic [7:0] t;
		if (c > esd_pkg::CH_NINE)
			t = c - (esd_pkg::CH_UC_A - 8'd10);
		else
			t = c - esd_pkg::CH_ZERO;
		return t[3:0];
	endfunction

	function automatic void add_char(inout decoded_t d, input logic [7:0] ch);
		d.chars[d.count] = ch;
		d.count++;
	endfunction

	// A byte seen in idle either opens an escape or passes straight through.
	function automatic void reenter_idle(inout decoded_t d, input logic [7:0] ch);
		if (ch == esd_pkg::CH_BACKSLASH)
			esc_mode = esd_pkg::MODE_ESC;
		else
			add_char(d, ch);
	endfunction

	// Advances the model by one input beat and returns the characters it emits.
	function automatic decoded_t decode_char(esd_pkg::in_beat_t b);
		decoded_t    d;
		logic [7:0]  c;
		logic [11:0] acc;
		bit          hit;
		d   = '0;
		c   = b.in_byte;
		hit = 1'b0;
		if (b.end_of_string) begin
			// End mark flushes any open octal or hex escape; a lone backslash is dropped.
			case (esc_mode)
				esd_pkg::MODE_OCT:  add_char(d, octal_acc[7:0]);
				esd_pkg::MODE_HEX0: add_char(d, esd_pkg::CH_X);
				esd_pkg::MODE_HEX1: begin
					add_char(d, esd_pkg::CH_X);
					add_char(d, first_hex);
				end
				default: ;
			endcase
			esc_mode  = esd_pkg::MODE_IDLE;
			octal_acc = '0;
			first_hex = '0;
		end else begin
			case (esc_mode)
				esd_pkg::MODE_ESC: begin
					esc_mode = esd_pkg::MODE_IDLE;
					for (int k = 0; k < 7; k++) begin
						if (!hit && c == ESC_LETTERS[k]) begin
							add_char(d, ESC_CODES[k]);
							hit = 1'b1;
						end
					end
					if (!hit) begin
						if (is_octal(c)) begin
							octal_acc = {6'd0, c[2:0]};
							esc_mode  = esd_pkg::MODE_OCT;
						end else if (c == esd_pkg::CH_X) begin
							esc_mode = esd_pkg::MODE_HEX0;
						end else begin
							add_char(d, c);
						end
					end
				end
				esd_pkg::MODE_OCT: begin
					if (is_octal(c)) begin
						// Shift in the digit; reaching 256 emits the low byte at once.
						acc = {octal_acc, 3'b000} | {9'd0, c[2:0]};
						if (acc >= 12'd256) begin
							add_char(d, acc[7:0]);
							octal_acc = '0;
							esc_mode  = esd_pkg::MODE_IDLE;
						end else begin
							octal_acc = acc[8:0];
						end
					end else begin
						add_char(d, octal_acc[7:0]);
						octal_acc = '0;
						esc_mode  = esd_pkg::MODE_IDLE;
						reenter_idle(d, c);
					end
				end
				esd_pkg::MODE_HEX0: begin
					if (is_hex(c)) begin
						first_hex = c;
						esc_mode  = esd_pkg::MODE_HEX1;
					end else begin
						add_char(d, esd_pkg::CH_X);
						esc_mode = esd_pkg::MODE_IDLE;
						reenter_idle(d, c);
					end
				end
				esd_pkg::MODE_HEX1: begin
					esc_mode = esd_pkg::MODE_IDLE;
					if (is_hex(c)) begin
						add_char(d, {hex_val(first_hex), hex_val(c)});
					end else begin
						add_char(d, esd_pkg::CH_X);
						add_char(d, first_hex);
						reenter_idle(d, c);
					end
					first_hex = '0;
				end
				default: begin
					esc_mode = esd_pkg::MODE_IDLE;
					reenter_idle(d, c);
				end
			endcase
		end
		return d;
	endfunction

	function automatic esd_pkg::in_beat_t mk_beat(logic [7:0] c, logic eos);
		esd_pkg::in_beat_t b;
		b.in_byte       = c;
		b.end_of_string = eos;
		return b;
	endfunction

	function automatic logic [7:0] random_hex_digit();
		int n;
		n = $urandom_range(0, 21);
		if (n < 10)
			return esd_pkg::CH_ZERO + 8'(n);
		if (n < 16)
			return esd_pkg::CH_LC_A + 8'(n - 10);
		return esd_pkg::CH_UC_A + 8'(n - 16);
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("%0t: mismatch: %s", $time, msg);
	endtask

	// Offers one beat, after a random gap unless tx_steady is set, and records what it should produce.
	task automatic send_beat(esd_pkg::in_beat_t b, bit typed, decoded_t typed_want);
		decoded_t           d;
		esd_pkg::out_beat_t o;
		int                 gap;
		gap = tx_steady ? 0 : $urandom_range(0, 6);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= b;
		do @(posedge clk); while (!in_ready);
		d = decode_char(b);
		if (typed)
			d = typed_want;
		for (int i = 0; i < d.count; i++) begin
			o.out_byte = d.chars[i];
			o.out_last = (i == d.count - 1);
			pending_chars.push_back(o);
		end
	endtask

	// Stops offering input and waits until every expected beat has come out.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
	endtask

	// Output side: random stalls before each beat unless rx_steady is set, with one long hold-off set by rx_hold.
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall   = (rx_hold > 0) ? rx_hold : (rx_steady ? 0 : $urandom_range(0, 6));
			rx_hold = 0;
			repeat (stall) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Checker: each accepted output beat against the oldest expectation.
	always @(posedge clk) begin
		esd_pkg::out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected beat byte %h last %b",
					out_data.out_byte, out_data.out_last));
			end else begin
				want = pending_chars.pop_front();
				if (out_data.out_byte !== want.out_byte)
					report_mismatch($sformatf("out_byte got %h want %h",
						out_data.out_byte, want.out_byte));
				if (out_data.out_last !== want.out_last)
					report_mismatch($sformatf("out_last got %b want %b (byte %h)",
						out_data.out_last, want.out_last, want.out_byte));
			end
		end
	end

	// Main sequence: reset, directed table, random escape text, final drain.
	initial begin
		esd_pkg::in_beat_t seq[$];
		dir_row_t row;
		decoded_t want;
		logic [7:0] c;
		int sent;
		int ndig;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			row        = directed_rows[i];
			want.count = row.count;
			want.chars = {row.r2, row.r1, row.r0};
			send_beat(mk_beat(row.chr, row.eos), row.typed, want);
		end

		// Random part: mostly well-formed escapes with random content, plus noise.
		sent = 0;
		while (sent < 96) begin
			seq.delete();
			case ($urandom_range(0, 9))
				0, 1: seq.push_back(mk_beat(8'($urandom_range(0, 255)), 1'b0));
				2: begin
					seq.push_back(mk_beat(esd_pkg::CH_BACKSLASH, 1'b0));
					seq.push_back(mk_beat(ESC_LETTERS[$urandom_range(0, 6)], 1'b0));
				end
				3: begin
					// Octal run; a high first digit with three digits overflows 255.
					seq.push_back(mk_beat(esd_pkg::CH_BACKSLASH, 1'b0));
					ndig = $urandom_range(1, 3);
					for (int k = 0; k < ndig; k++)
						seq.push_back(mk_beat(esd_pkg::CH_ZERO + 8'($urandom_range(0, 7)),
							1'b0));
					if ($urandom_range(0, 1))
						seq.push_back(mk_beat(8'($urandom_range(0, 255)), 1'b0));
				end
				4: begin
					seq.push_back(mk_beat(esd_pkg::CH_BACKSLASH, 1'b0));
					seq.push_back(mk_beat(esd_pkg::CH_X, 1'b0));
					seq.push_back(mk_beat(random_hex_digit(), 1'b0));
					seq.push_back(mk_beat(random_hex_digit(), 1'b0));
				end
				5: begin
					// Broken hex escape, failing on the first or second character.
					seq.push_back(mk_beat(esd_pkg::CH_BACKSLASH, 1'b0));
					seq.push_back(mk_beat(esd_pkg::CH_X, 1'b0));
					if ($urandom_range(0, 1))
						seq.push_back(mk_beat(random_hex_digit(), 1'b0));
					do c = 8'($urandom_range(0, 255)); while (is_hex(c));
					seq.push_back(mk_beat(c, 1'b0));
				end
				6: begin
					seq.push_back(mk_beat(esd_pkg::CH_BACKSLASH, 1'b0));
					seq.push_back(mk_beat(8'($urandom_range(0, 255)), 1'b0));
				end
				7: begin
					// End mark landing in idle or on each kind of open escape.
					case ($urandom_range(0, 4))
						1: seq.push_back(mk_beat(esd_pkg::CH_BACKSLASH, 1'b0));
						2: begin
							seq.push_back(mk_beat(esd_pkg::CH_BACKSLASH, 1'b0));
							seq.push_back(mk_beat(esd_pkg::CH_ZERO + 8'($urandom_range(0, 7)),
								1'b0));
						end
						3: begin
							seq.push_back(mk_beat(esd_pkg::CH_BACKSLASH, 1'b0));
							seq.push_back(mk_beat(esd_pkg::CH_X, 1'b0));
						end
						4: begin
							seq.push_back(mk_beat(esd_pkg::CH_BACKSLASH, 1'b0));
							seq.push_back(mk_beat(esd_pkg::CH_X, 1'b0));
							seq.push_back(mk_beat(random_hex_digit(), 1'b0));
						end
						default: ;
					endcase
					seq.push_back(mk_beat(8'($urandom_range(0, 255)), 1'b1));
				end
				default: seq.push_back(mk_beat(8'($urandom_range(0, 255)),
					$urandom_range(0, 3) == 0));
			endcase
			foreach (seq[j]) begin
				// Long output hold-off while input keeps coming, then a full drain.
				if (sent == 30)
					rx_hold = 80;
				if (sent == 70)
					drain_results();
				tx_steady = (sent >= 30 && sent < 50) || (sent >= 80 && sent < 92);
				rx_steady = (sent >= 80 && sent < 92);
				send_beat(seq[j], 1'b0, '0);
				sent++;
			end
		end

		drain_results();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0 && pending_chars.size() == 0)
			$display("escape_sequence_decoder_unit regression: pass");
		else
			$display("escape_sequence_decoder_unit regression: fail");
		$finish;
	end

	// Watchdog.
	initial begin
		#1000000;
		$display("escape_sequence_decoder_unit regression: fail");
		$finish;
	end

endmodule
